[hdl/stream_pattern_replace_defines.svh]
// Assertion helpers for the checker module.
`ifndef STREAM_PATTERN_REPLACE_DEFINES_SVH
`define STREAM_PATTERN_REPLACE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SPR_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SPR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

[hdl/spr_pkg.sv]
package spr_pkg;

	localparam int BYTE_W              = 8;
	localparam int CFG_DATA_W          = 64;
	localparam int CFG_IDX_W           = 2;
	localparam int LEN_W               = 4;
	localparam int MAX_PATTERN_DEF     = 8;
	localparam int MAX_REPLACEMENT_DEF = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_BYTES      = 2'd0,
		REG_PATTERN_LENGTH     = 2'd1,
		REG_REPLACEMENT_BYTES  = 2'd2,
		REG_REPLACEMENT_LENGTH = 2'd3
	} cfg_reg_t;

	// Control side of one result group.
	typedef struct packed {
		logic marker;   // group is a lone end marker
		logic last;     // final group of the string
	} bundle_ctl_t;

endpackage

[hdl/spr_window.sv]
module spr_window import spr_pkg::*; #(
	parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
	parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF,
	localparam int PLEN_W = $clog2(MAX_PATTERN + 1),
	localparam int RLEN_W = $clog2(MAX_REPLACEMENT + 1),
	localparam int RES_N  = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT,
	localparam int CNT_W  = $clog2(RES_N + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear_fill,
	input  logic                          advance,
	input  logic [PLEN_W-1:0]             plen,
	input  logic [RLEN_W-1:0]             rlen,
	input  logic [CFG_DATA_W-1:0]         pattern,
	input  logic [CFG_DATA_W-1:0]         replacement,
	input  logic [BYTE_W-1:0]             data_in,
	input  logic                          last_in,
	output logic [RES_N-1:0][BYTE_W-1:0]  res_bytes,
	output logic [CNT_W-1:0]              res_cnt,
	output bundle_ctl_t                   res_ctl
);

	localparam int WIN_IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_q;
	logic [PLEN_W-1:0]                  fill_q;

	logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_w;
	logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_shift;
	logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_d;
	logic [PLEN_W-1:0]                  fill_eff;
	logic [PLEN_W-1:0]                  f_inc;
	logic [PLEN_W-1:0]                  fill_d;
	logic                               fire;
	logic                               hit;
	logic                               marker;

	always_comb begin
		fill_eff = (fill_q >= plen) ? '0 : fill_q;
		win_w = window_q;
		win_w[fill_eff[WIN_IW-1:0]] = data_in;
		f_inc = fill_eff + PLEN_W'(1);
		fire  = (f_inc == plen);

		hit = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (PLEN_W'(i) < plen && win_w[i] != pattern[BYTE_W*i +: BYTE_W]) begin
				hit = 1'b0;
			end
		end

		win_shift = win_w;
		for (int i = 0; i < MAX_PATTERN - 1; i++) begin
			win_shift[i] = win_w[i+1];
		end

		res_bytes = '0;
		res_cnt   = '0;
		marker    = 1'b0;
		window_d  = win_w;
		if (plen == '0) begin
			res_bytes[0] = data_in;
			res_cnt      = CNT_W'(1);
			fill_d       = '0;
		end else if (fire && hit) begin
			for (int i = 0; i < MAX_REPLACEMENT; i++) begin
				res_bytes[i] = replacement[BYTE_W*i +: BYTE_W];
			end
			res_cnt = CNT_W'(rlen);
			fill_d  = '0;
		end else if (fire) begin
			// Miss: oldest byte goes out; on last the whole window follows.
			for (int i = 0; i < MAX_PATTERN; i++) begin
				res_bytes[i] = win_w[i];
			end
			res_cnt  = last_in ? CNT_W'(plen) : CNT_W'(1);
			fill_d   = plen - PLEN_W'(1);
			window_d = win_shift;
		end else begin
			for (int i = 0; i < MAX_PATTERN; i++) begin
				res_bytes[i] = win_w[i];
			end
			res_cnt = last_in ? CNT_W'(f_inc) : '0;
			fill_d  = f_inc;
		end

		if (last_in) begin
			fill_d = '0;
		end
		if (last_in && res_cnt == '0) begin
			marker    = 1'b1;
			res_cnt   = CNT_W'(1);
			res_bytes = '0;
		end

		res_ctl.marker = marker;
		res_ctl.last   = last_in;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			window_q <= window_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (clear_fill) begin
			fill_q <= '0;
		end else if (advance) begin
			fill_q <= fill_d;
		end
	end

endmodule

[hdl/spr_emit.sv]
module spr_emit import spr_pkg::*; #(
	parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
	parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF,
	localparam int RES_N = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT,
	localparam int CNT_W = $clog2(RES_N + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [RES_N-1:0][BYTE_W-1:0]  ld_bytes,
	input  logic [CNT_W-1:0]              ld_cnt,
	input  bundle_ctl_t                   ld_ctl,
	output logic                          free,
	output logic                          rslt_valid,
	input  logic                          rslt_ready,
	output logic [BYTE_W-1:0]             out_byte,
	output logic                          out_valid,
	output logic                          out_last
);

	localparam int IDX_W = (RES_N > 1) ? $clog2(RES_N) : 1;

	logic [RES_N-1:0][BYTE_W-1:0] bytes_s2;
	logic [CNT_W-1:0]             cnt_s2;
	bundle_ctl_t                  ctl_s2;
	logic                         busy_s2;
	logic [IDX_W-1:0]             idx_q;
	logic                         last_one;

	assign last_one   = (CNT_W'(idx_q) == cnt_s2 - CNT_W'(1));
	assign free       = !busy_s2 || (rslt_ready && last_one);
	assign rslt_valid = busy_s2;
	assign out_byte   = bytes_s2[idx_q];
	assign out_valid  = !ctl_s2.marker;
	assign out_last   = ctl_s2.last && last_one;

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_s2 <= ld_bytes;
			cnt_s2   <= ld_cnt;
			ctl_s2   <= ld_ctl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s2 <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			busy_s2 <= 1'b1;
			idx_q   <= '0;
		end else if (busy_s2 && rslt_ready) begin
			if (last_one) begin
				busy_s2 <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

endmodule

[hdl/stream_pattern_replace.sv]
// Greedy, non-overlapping find and replace over a byte stream.
// Input channel in_valid/in_ready moves one byte (in_byte, in_last) per
// transfer. Result channel rslt_valid/rslt_ready moves one result per
// transfer: out_byte, out_valid (0 on an end-only marker), out_last.
// Configuration is a write port (cfg_we, cfg_index, cfg_data) with no wait;
// write it only while the stream is idle. Writing the pattern length drops
// any bytes held in the match window.
// Flow: an accepted byte is held in the input register; once the output buffer
// is free, its result group, if it has any, is loaded into the output buffer,
// which shows the results one at a time on the result channel.
// Throughput: one byte per cycle while rslt_ready is high and each byte
// yields at most one result. A byte that yields n results holds the output
// buffer until the single result port has passed all n on, one per cycle.
// Stalls: with rslt_ready low the current result holds; one more byte waits
// in the input register, then in_ready drops.
// Reset (arst_n low): control and config registers cleared to zero, window empty, pass-through.
module stream_pattern_replace import spr_pkg::*; #(
	parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
	parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [BYTE_W-1:0]     in_byte,
	input  logic                  in_last,
	output logic                  rslt_valid,
	input  logic                  rslt_ready,
	output logic [BYTE_W-1:0]     out_byte,
	output logic                  out_valid,
	output logic                  out_last
);

	localparam int PLEN_W = $clog2(MAX_PATTERN + 1);
	localparam int RLEN_W = $clog2(MAX_REPLACEMENT + 1);
	localparam int RES_N  = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
	localparam int CNT_W  = $clog2(RES_N + 1);

	// Configuration registers
	logic [CFG_DATA_W-1:0] pattern_bytes_q;
	logic [LEN_W-1:0]      pattern_length_q;
	logic [CFG_DATA_W-1:0] replacement_bytes_q;
	logic [LEN_W-1:0]      replacement_length_q;
	logic                  clear_fill;

	// Input register
	logic [BYTE_W-1:0] data_s1;
	logic              last_s1;
	logic              valid_s1;

	logic [PLEN_W-1:0]             plen;
	logic [RLEN_W-1:0]             rlen;
	logic                          advance;
	logic                          emit_free;
	logic [RES_N-1:0][BYTE_W-1:0]  res_bytes;
	logic [CNT_W-1:0]              res_cnt;
	bundle_ctl_t                   res_ctl;

	// Decode configuration writes; a pattern length write empties the window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bytes_q      <= '0;
			pattern_length_q     <= '0;
			replacement_bytes_q  <= '0;
			replacement_length_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PATTERN_BYTES:      pattern_bytes_q      <= cfg_data;
				REG_PATTERN_LENGTH:     pattern_length_q     <= cfg_data[LEN_W-1:0];
				REG_REPLACEMENT_BYTES:  replacement_bytes_q  <= cfg_data;
				REG_REPLACEMENT_LENGTH: replacement_length_q <= cfg_data[LEN_W-1:0];
			endcase
		end
	end

	assign clear_fill = cfg_we && (cfg_reg_t'(cfg_index) == REG_PATTERN_LENGTH);

	// Saturate lengths to what the window and buffer can hold.
	assign plen = (pattern_length_q > LEN_W'(MAX_PATTERN)) ?
		PLEN_W'(MAX_PATTERN) : PLEN_W'(pattern_length_q);
	assign rlen = (replacement_length_q > LEN_W'(MAX_REPLACEMENT)) ?
		RLEN_W'(MAX_REPLACEMENT) : RLEN_W'(replacement_length_q);

	// Advance the held byte once the output buffer is empty or empties now.
	assign advance  = valid_s1 && emit_free;
	assign in_ready = !valid_s1 || emit_free;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	spr_window #(
		.MAX_PATTERN     (MAX_PATTERN),
		.MAX_REPLACEMENT (MAX_REPLACEMENT)
	) u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear_fill  (clear_fill),
		.advance     (advance),
		.plen        (plen),
		.rlen        (rlen),
		.pattern     (pattern_bytes_q),
		.replacement (replacement_bytes_q),
		.data_in     (data_s1),
		.last_in     (last_s1),
		.res_bytes   (res_bytes),
		.res_cnt     (res_cnt),
		.res_ctl     (res_ctl)
	);

	// Load the result group only when the byte produced something.
	spr_emit #(
		.MAX_PATTERN     (MAX_PATTERN),
		.MAX_REPLACEMENT (MAX_REPLACEMENT)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance && (res_cnt != '0)),
		.ld_bytes   (res_bytes),
		.ld_cnt     (res_cnt),
		.ld_ctl     (res_ctl),
		.free       (emit_free),
		.rslt_valid (rslt_valid),
		.rslt_ready (rslt_ready),
		.out_byte   (out_byte),
		.out_valid  (out_valid),
		.out_last   (out_last)
	);

endmodule

[hdl/spr_checker.sv]
`include "stream_pattern_replace_defines.svh"

module spr_checker import spr_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              rslt_valid,
	input logic              rslt_ready,
	input logic [BYTE_W-1:0] out_byte,
	input logic              out_valid,
	input logic              out_last
);

	// A stalled result holds.
	`SPR_ASSERT_NEXT(a_stall_hold, rslt_valid && !rslt_ready, rslt_valid && $stable(out_byte) && $stable(out_valid) && $stable(out_last))

	// An end-only marker closes the string and carries a zero byte.
	`SPR_ASSERT(a_marker_form, rslt_valid && !out_valid, out_last && (out_byte == '0))

	// Input backpressure only comes from a pending result.
	`SPR_ASSERT(a_ready_cause, !in_ready, rslt_valid)

endmodule

bind stream_pattern_replace spr_checker u_spr_checker (.*);

[dv/stream_pattern_replace_tb.sv]
`timescale 1ns / 100ps

module stream_pattern_replace_tb import spr_pkg::*; ();

	// Settle time after the last expected result: a byte that yields nothing
	// may still sit in the input register.
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 36;
	localparam int LONG_HOLD     = 250;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              valid;
		logic              last;
	} replace_result_t;

	// Scoreboard: tracks the replacement state and holds the expected results.
	class replace_scoreboard;
		logic [CFG_DATA_W-1:0] pat_bytes = '0;
		logic [CFG_DATA_W-1:0] rep_bytes = '0;
		logic [LEN_W-1:0]      pat_len   = '0;
		logic [LEN_W-1:0]      rep_len   = '0;
		logic [BYTE_W-1:0]     window [MAX_PATTERN_DEF];
		int unsigned           fill      = 0;
		replace_result_t       expected_out[$];
		int unsigned           accepted  = 0;
		int unsigned           checked   = 0;
		int unsigned           replaced  = 0;
		int unsigned           markers   = 0;
		int unsigned           errors    = 0;

		function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_PATTERN_BYTES:      pat_bytes = data;
				REG_PATTERN_LENGTH: begin
					pat_len = data[LEN_W-1:0];
					fill    = 0;
				end
				REG_REPLACEMENT_BYTES:  rep_bytes = data;
				REG_REPLACEMENT_LENGTH: rep_len   = data[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		function void push(logic [BYTE_W-1:0] b, logic v, logic l);
			replace_result_t r;
			r.data  = b;
			r.valid = v;
			r.last  = l;
			expected_out.push_back(r);
		endfunction

		// Work out the results of one accepted input byte.
		function void take_byte(logic [BYTE_W-1:0] b, logic is_last);
			int unsigned plen, rlen, n, i;
			bit hit;
			accepted++;
			plen = (pat_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : pat_len;
			rlen = (rep_len > MAX_REPLACEMENT_DEF) ? MAX_REPLACEMENT_DEF : rep_len;
			if (plen == 0) begin
				push(b, 1'b1, is_last);
				fill = 0;
				return;
			end
			if (fill >= plen)
				fill = 0;
			window[fill] = b;
			fill++;
			n = 0;
			if (fill == plen) begin
				hit = 1'b1;
				for (i = 0; i < plen; i++)
					if (window[i] != pat_bytes[8*i +: 8])
						hit = 1'b0;
				if (hit) begin
					replaced++;
					for (i = 0; i < rlen; i++) begin
						push(rep_bytes[8*i +: 8], 1'b1, 1'b0);
						n++;
					end
					fill = 0;
				end else begin
					push(window[0], 1'b1, 1'b0);
					n++;
					for (i = 1; i < fill; i++)
						window[i-1] = window[i];
					fill--;
				end
			end
			if (is_last) begin
				for (i = 0; i < fill; i++) begin
					push(window[i], 1'b1, 1'b0);
					n++;
				end
				fill = 0;
				if (n == 0) begin
					push('0, 1'b0, 1'b1);
					markers++;
				end else begin
					expected_out[expected_out.size()-1].last = 1'b1;
				end
			end
		endfunction

		function void note_error(string msg);
			errors++;
			if (errors <= 10)
				$display("ERROR: %s", msg);
		endfunction

		function void check_out(replace_result_t got);
			replace_result_t want;
			checked++;
			if (expected_out.size() == 0) begin
				note_error($sformatf("unexpected result byte %02h valid %b last %b",
					got.data, got.valid, got.last));
				return;
			end
			want = expected_out.pop_front();
			if (got.data !== want.data || got.valid !== want.valid || got.last !== want.last)
				note_error($sformatf("result %0d: expected byte %02h valid %b last %b, got byte %02h valid %b last %b",
					checked, want.data, want.valid, want.last, got.data, got.valid, got.last));
		endfunction

		function void close_out();
			if (expected_out.size() != 0) begin
				$display("ERROR: %0d expected results never arrived", expected_out.size());
				errors += expected_out.size();
			end
		endfunction
	endclass

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  in_valid   = 1'b0;
	logic                  in_ready;
	logic [BYTE_W-1:0]     in_byte    = '0;
	logic                  in_last    = 1'b0;
	logic                  rslt_valid;
	logic                  rslt_ready = 1'b0;
	logic [BYTE_W-1:0]     out_byte;
	logic                  out_valid;
	logic                  out_last;

	replace_scoreboard sb = new();

	// Idling switches per phase; the sink picks up a long hold request once.
	bit          send_idle    = 1'b1;
	bit          recv_idle    = 1'b1;
	int unsigned hold_request = 0;

	// Pattern in force, for building strings that hit it.
	logic [CFG_DATA_W-1:0] cur_pat  = '0;
	int unsigned           cur_plen = 0;
	int unsigned           strings_sent  = 0;
	int unsigned           settings_used = 0;

	stream_pattern_replace i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.rslt_valid (rslt_valid),
		.rslt_ready (rslt_ready),
		.out_byte   (out_byte),
		.out_valid  (out_valid),
		.out_last   (out_last)
	);

	always #5 clk = ~clk;

	// Hard stop for a hung run.
	initial begin
		#5_000_000;
		$display("TIMEOUT: run did not finish");
		$display("DONE: errors detected");
		$finish;
	end

	// Offer one byte; keep valid up after the transfer so a zero gap
	// never lowers and raises it in the same step.
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic is_last);
		int unsigned gap;
		gap = send_idle ? $urandom_range(0, 11) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= is_last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.take_byte(b, is_last);
	endtask

	// Drop valid, drain every expected result, then give the block time
	// to finish bytes that yield nothing.
	task automatic wait_idle();
		int unsigned guard;
		in_valid <= 1'b0;
		guard = 0;
		while (sb.expected_out.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; cfg_we drops again before the task returns, so write
	// enables never toggle twice in one step.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] pbytes,
			input logic [CFG_DATA_W-1:0] plen, input logic [CFG_DATA_W-1:0] rbytes,
			input logic [CFG_DATA_W-1:0] rlen);
		write_reg(REG_PATTERN_BYTES, pbytes);
		write_reg(REG_PATTERN_LENGTH, plen);
		write_reg(REG_REPLACEMENT_BYTES, rbytes);
		write_reg(REG_REPLACEMENT_LENGTH, rlen);
		cur_pat  = pbytes;
		cur_plen = (plen[LEN_W-1:0] > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : plen[LEN_W-1:0];
		settings_used++;
	endtask

	// Build a string: mostly pattern hits, near misses and pattern bytes,
	// sometimes plain noise. Mark the final byte as last.
	task automatic send_random_string();
		logic [BYTE_W-1:0] str[$];
		int unsigned len_goal, style, k, j;
		len_goal = $urandom_range(1, 20);
		style    = $urandom_range(0, 9);
		while (str.size() < len_goal) begin
			if (style < 7 && cur_plen > 0) begin
				case ($urandom_range(0, 3))
					0, 1: begin
						for (j = 0; j < cur_plen; j++)
							str.push_back(cur_pat[8*j +: 8]);
					end
					2: begin
						k = $urandom_range(0, cur_plen - 1);
						for (j = 0; j < k; j++)
							str.push_back(cur_pat[8*j +: 8]);
						str.push_back(BYTE_W'($urandom_range(0, 255)));
					end
					default: str.push_back(cur_pat[8*$urandom_range(0, cur_plen - 1) +: 8]);
				endcase
			end else begin
				str.push_back(BYTE_W'($urandom_range(0, 255)));
			end
		end
		for (j = 0; j < str.size(); j++)
			send_byte(str[j], j == str.size() - 1);
		strings_sent++;
	endtask

	// Result sink: draw a stall per result, honor one long hold, check each
	// transfer against the oldest expectation.
	initial begin : result_sink
		int unsigned stall;
		replace_result_t got;
		wait (arst_n === 1'b1);
		forever begin
			stall = recv_idle ? $urandom_range(0, 11) : 0;
			if (hold_request != 0) begin
				stall        = hold_request;
				hold_request = 0;
			end
			if (stall != 0) begin
				rslt_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rslt_ready <= 1'b1;
			@(posedge clk);
			while (!rslt_valid)
				@(posedge clk);
			got.data  = out_byte;
			got.valid = out_valid;
			got.last  = out_last;
			sb.check_out(got);
		end
	end

	initial begin : stimulus
		int unsigned p, j, phase_end, plen_w, rlen_w;
		logic [CFG_DATA_W-1:0] pbytes, plen_d, rlen_d;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pass-through straight out of reset, byte extremes.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		wait_idle();

		// Two-byte pattern expanded to three bytes; a near miss right
		// before a hit.
		set_config(64'h4241, 2, 64'h7A7978, 3);
		send_byte(8'h5A, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h42, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h42, 1'b1);
		wait_idle();

		// Empty replacement: a string that is exactly the pattern leaves
		// only the end marker; a lone partial window gets flushed.
		set_config(64'h4241, 2, 64'h0, 0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h42, 1'b1);
		send_byte(8'h41, 1'b1);
		wait_idle();

		// Oversized lengths saturate to the full eight bytes.
		set_config('1, 15, 64'h0123456789ABCDEF, 15);
		for (j = 0; j < 8; j++)
			send_byte(8'hFF, j == 7);
		wait_idle();

		// Rewrite the pattern length mid-string: held bytes are dropped,
		// so the later bytes cannot complete the match.
		set_config(64'h434343, 3, 64'h2A, 1);
		send_byte(8'h43, 1'b0);
		send_byte(8'h43, 1'b0);
		wait_idle();
		write_reg(REG_PATTERN_LENGTH, 3);
		send_byte(8'h43, 1'b0);
		send_byte(8'h43, 1'b1);
		wait_idle();

		// Random phases, each with its own register setting and idling mix.
		for (p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 9))
				0:       plen_w = 0;
				1:       plen_w = $urandom_range(9, 15);
				2, 3:    plen_w = MAX_PATTERN_DEF;
				default: plen_w = $urandom_range(1, 8);
			endcase
			rlen_w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
			pbytes = {$urandom, $urandom};
			// A two-letter alphabet gives self-overlapping patterns.
			if ($urandom_range(0, 1))
				for (j = 0; j < 8; j++)
					pbytes[8*j +: 8] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
			// Upper bits of the length writes are don't-care; exercise them.
			plen_d = {$urandom, $urandom};
			rlen_d = {$urandom, $urandom};
			if ($urandom_range(0, 1)) begin
				plen_d = '0;
				rlen_d = '0;
			end
			plen_d[LEN_W-1:0] = LEN_W'(plen_w);
			rlen_d[LEN_W-1:0] = LEN_W'(rlen_w);
			set_config(pbytes, plen_d, {$urandom, $urandom}, rlen_d);

			send_idle = (p == 1 || p == 2) ? 1'b0 : 1'($urandom_range(0, 1));
			recv_idle = (p == 1) ? 1'b0 : ((p == 2) ? 1'b1 : 1'($urandom_range(0, 1)));
			// Stall the sink for a long stretch while bytes keep coming, so
			// the block backs up and drops in_ready.
			if (p == 2)
				hold_request = LONG_HOLD;

			phase_end = sb.accepted + PHASE_ITEMS;
			while (sb.accepted < phase_end)
				send_random_string();
			wait_idle();
		end

		sb.close_out();
		$display("Run covered %0d bytes in %0d strings over %0d register settings.",
			sb.accepted, strings_sent + 6, settings_used);
		$display("Checked %0d results: %0d pattern hits, %0d lone end markers.",
			sb.checked, sb.replaced, sb.markers);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hdl
hdl/spr_pkg.sv
hdl/spr_window.sv
hdl/spr_emit.sv
hdl/stream_pattern_replace.sv
hdl/spr_checker.sv
dv/stream_pattern_replace_tb.sv
